### sv/nspa_pkg.sv
`timescale 1ns / 1ps

package nspa_pkg;

    // Fixed field widths of the channel payloads, and the default pool size
    localparam int OP_W          = 2;
    localparam int SLOT_W        = 5;
    localparam int STAT_W        = 2;
    localparam int DEF_POOL_SIZE = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_DEL   = 2'd1,
        OP_LIST  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_NOT_ACTIVE = 2'd2,
        ST_EMPTY      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_WALK,
        S_DEL_FREE,
        S_LIST
    } t_state;

    // Link memory port strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    // Sequencer status seen by the top level
    typedef struct packed {
        logic idle;
        logic free_empty;
        logic active_empty;
    } t_seq_stat;

endpackage

### sv/nspa_if.sv
`timescale 1ns / 1ps

interface nspa_in_if import nspa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] slot_number;

    modport source (output valid, operation, slot_number, input ready);
    modport sink   (input valid, operation, slot_number, output ready);
endinterface

interface nspa_out_if import nspa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_number_res;
    logic              last;

    modport source (output valid, status, slot_number_res, last, input ready);
    modport sink   (input valid, status, slot_number_res, last, output ready);
endinterface

### sv/nspa_link_mem.sv
`timescale 1ns / 1ps

module nspa_link_mem import nspa_pkg::*; #(
    parameter  int POOL_SIZE = DEF_POOL_SIZE,
    localparam int LW        = $clog2(POOL_SIZE + 1),
    localparam int AW        = $clog2(POOL_SIZE)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [LW-1:0] i_wr_data,
    output logic [LW-1:0] o_rd_data
);

    logic [LW-1:0] r_mem [POOL_SIZE];
    logic          r_vld [POOL_SIZE];
    logic [LW-1:0] r_rd_data;

    // Unwritten entry reads as its reset link: next slot, last one null
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr]
                                          : LW'(i_rd_addr) + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_SIZE; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (i_ctl.wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/nspa_seq.sv
`timescale 1ns / 1ps

module nspa_seq import nspa_pkg::*; #(
    parameter  int POOL_SIZE = DEF_POOL_SIZE,
    localparam int LW        = $clog2(POOL_SIZE + 1),
    localparam int AW        = $clog2(POOL_SIZE)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nspa_in_if.sink       i_in,
    nspa_out_if.source    o_out,
    output t_mem_ctl      o_mem_ctl,
    output logic [AW-1:0] o_rd_addr,
    output logic [AW-1:0] o_wr_addr,
    output logic [LW-1:0] o_wr_data,
    input  logic [LW-1:0] i_rd_data,
    output t_seq_stat     o_stat
);

    localparam int            CW   = $clog2(POOL_SIZE);
    localparam int            MW   = (LW > SLOT_W) ? LW : SLOT_W;
    localparam logic [LW-1:0] NULL = LW'(POOL_SIZE);
    localparam logic [CW-1:0] CMAX = CW'(POOL_SIZE - 1);

    t_state            r_state, n_state;
    logic [LW-1:0]     r_free_head, n_free_head;
    logic [LW-1:0]     r_active_head, n_active_head;
    logic [LW-1:0]     r_cur, n_cur;
    logic [LW-1:0]     r_prev, n_prev;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_num, n_num;
    logic              r_ovld, n_ovld;
    t_status           r_ostat, n_ostat;
    logic [SLOT_W-1:0] r_oslot, n_oslot;
    logic              r_olast, n_olast;

    logic     out_free;
    logic     in_ready;
    logic     fh_ok, ah_ok, rd_ok, prev_ok, hit, list_last;
    t_mem_ctl mem_ctl;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [LW-1:0] wr_data;

    assign out_free  = !r_ovld || o_out.ready;
    assign fh_ok     = r_free_head < NULL;
    assign ah_ok     = r_active_head < NULL;
    assign rd_ok     = i_rd_data < NULL;
    assign prev_ok   = r_prev < NULL;
    assign hit       = MW'(r_cur) == MW'(r_num);
    assign list_last = !rd_ok || (r_cnt == CMAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_free_head   <= '0;
            r_active_head <= NULL;
            r_ovld        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_free_head   <= n_free_head;
            r_active_head <= n_active_head;
            r_ovld        <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_cnt   <= n_cnt;
        r_num   <= n_num;
        r_ostat <= n_ostat;
        r_oslot <= n_oslot;
        r_olast <= n_olast;
    end

    // Output register is always empty once an item is in flight, except
    // during a list, which therefore waits on out_free per result.
    always_comb begin
        n_state       = r_state;
        n_free_head   = r_free_head;
        n_active_head = r_active_head;
        n_cur         = r_cur;
        n_prev        = r_prev;
        n_cnt         = r_cnt;
        n_num         = r_num;
        n_ovld        = r_ovld && !o_out.ready;
        n_ostat       = r_ostat;
        n_oslot       = r_oslot;
        n_olast       = r_olast;
        mem_ctl       = '0;
        rd_addr       = '0;
        wr_addr       = '0;
        wr_data       = '0;
        in_ready      = 1'b0;

        case (r_state)
            S_IDLE: begin
                in_ready = out_free;
                if (i_in.valid && out_free) begin
                    n_num = i_in.slot_number;
                    case (t_op'(i_in.operation))
                        OP_ALLOC: begin
                            if (!fh_ok) begin
                                n_ovld  = 1'b1;
                                n_ostat = ST_EXHAUSTED;
                                n_oslot = '0;
                                n_olast = 1'b1;
                            end else begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = r_free_head[AW-1:0];
                                n_state       = S_ALLOC;
                            end
                        end
                        OP_DEL: begin
                            if (!ah_ok) begin
                                n_ovld  = 1'b1;
                                n_ostat = ST_NOT_ACTIVE;
                                n_oslot = '0;
                                n_olast = 1'b1;
                            end else begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = r_active_head[AW-1:0];
                                n_cur         = r_active_head;
                                n_prev        = NULL;
                                n_cnt         = '0;
                                n_state       = S_WALK;
                            end
                        end
                        OP_LIST: begin
                            if (!ah_ok) begin
                                n_ovld  = 1'b1;
                                n_ostat = ST_EMPTY;
                                n_oslot = '0;
                                n_olast = 1'b1;
                            end else begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = r_active_head[AW-1:0];
                                n_cur         = r_active_head;
                                n_cnt         = '0;
                                n_state       = S_LIST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ALLOC: begin
                // read data is link of the popped free head
                mem_ctl.wr_en = 1'b1;
                wr_addr       = r_free_head[AW-1:0];
                wr_data       = r_active_head;
                n_free_head   = i_rd_data;
                n_active_head = r_free_head;
                n_ovld        = 1'b1;
                n_ostat       = ST_OK;
                n_oslot       = SLOT_W'(r_free_head);
                n_olast       = 1'b1;
                n_state       = S_IDLE;
            end
            S_WALK: begin
                // read data is link of r_cur; r_num is the slot captured at the transfer
                if (hit) begin
                    if (prev_ok) begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = r_prev[AW-1:0];
                        wr_data       = i_rd_data;
                    end else begin
                        n_active_head = i_rd_data;
                    end
                    n_state = S_DEL_FREE;
                end else if (!rd_ok || (r_cnt == CMAX)) begin
                    n_ovld  = 1'b1;
                    n_ostat = ST_NOT_ACTIVE;
                    n_oslot = '0;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = i_rd_data[AW-1:0];
                    n_prev        = r_cur;
                    n_cur         = i_rd_data;
                    n_cnt         = r_cnt + CW'(1);
                end
            end
            S_DEL_FREE: begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = r_cur[AW-1:0];
                wr_data       = r_free_head;
                n_free_head   = r_cur;
                n_ovld        = 1'b1;
                n_ostat       = ST_OK;
                n_oslot       = '0;
                n_olast       = 1'b1;
                n_state       = S_IDLE;
            end
            S_LIST: begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_ostat = ST_OK;
                    n_oslot = SLOT_W'(r_cur);
                    n_olast = list_last;
                    if (list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = i_rd_data[AW-1:0];
                        n_cur         = i_rd_data;
                        n_cnt         = r_cnt + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_in.ready            = in_ready;
    assign o_out.valid           = r_ovld;
    assign o_out.status          = r_ostat;
    assign o_out.slot_number_res = r_oslot;
    assign o_out.last            = r_olast;

    assign o_mem_ctl = mem_ctl;
    assign o_rd_addr = rd_addr;
    assign o_wr_addr = wr_addr;
    assign o_wr_data = wr_data;

    assign o_stat.idle         = (r_state == S_IDLE);
    assign o_stat.free_empty   = !fh_ok;
    assign o_stat.active_empty = !ah_ok;

endmodule

### sv/numbered_slot_pool_allocator_top.sv
// Sequence: allocate reads the free head's link at the input transfer, then S_ALLOC
//   pops the slot; delete walks the active list in S_WALK, then S_DEL_FREE frees it;
//   errors load the output register at the input transfer. One item at a time; a list
//   gives one result per cycle while the output register is empty or being taken.
// Reset (i_rst_n low, synchronous): free list 0..POOL_SIZE-1, active list empty,
//   link entries read as their reset links until first written; no clearing pass.
`timescale 1ns / 1ps

module numbered_slot_pool_allocator_top import nspa_pkg::*; #(
    parameter int POOL_SIZE = DEF_POOL_SIZE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nspa_in_if.sink    i_in,
    nspa_out_if.source o_out
);

    localparam int LW = $clog2(POOL_SIZE + 1);
    localparam int AW = $clog2(POOL_SIZE);

    // Link memory port between sequencer and table
    t_mem_ctl      mem_ctl;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [LW-1:0] wr_data;
    logic [LW-1:0] rd_data;
    t_seq_stat     seq_stat;

    // Sequencer: owns free/active heads, walk pointers and the output register.
    // Each walk step issues one link read and consumes it the next cycle.
    nspa_seq #(
        .POOL_SIZE (POOL_SIZE)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_mem_ctl (mem_ctl),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .i_rd_data (rd_data),
        .o_stat    (seq_stat)
    );

    // Next-link table: one write and one registered read per cycle, with
    // per-entry valid bits standing in for the reset contents.
    nspa_link_mem #(
        .POOL_SIZE (POOL_SIZE)
    ) u_link_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // Input is taken only between items
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> seq_stat.idle)
        else $error("input ready while an item is in flight");

    // Every slot but one being freed sits on one of the two lists, so both cannot be empty
    a_lists_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(seq_stat.free_empty && seq_stat.active_empty))
        else $error("free and active lists both empty");

    a_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.operation == OP_ALLOC && seq_stat.free_empty)
        |=> (o_out.valid && o_out.status == ST_EXHAUSTED && o_out.last))
        else $error("allocate on empty pool did not report exhaustion");

    a_list_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.operation == OP_LIST && seq_stat.active_empty)
        |=> (o_out.valid && o_out.status == ST_EMPTY && o_out.last))
        else $error("list of empty active set did not report empty");

endmodule
